### design/signed_int_to_decimal_ascii_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to decimal text block
// Shared property forms: same-cycle implication and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SITDA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sitda assertion failed");

// antecedent implies consequent in the next cycle
`define SITDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sitda assertion failed");

`endif

### design/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Types and constants shared by the integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int CNT_W       = 4;
   localparam int PROD_W      = 64;

   localparam logic [CNT_W-1:0]   DIGIT_SLOTS = 4'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;

   // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
   localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
   localparam int                 RECIP_SHIFT = 35;
   localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture a new value
      logic mul;         // register magnitude times reciprocal
      logic div;         // store one digit, shift magnitude down
      logic emit_sign;   // load '-' into the output register
      logic emit_digit;  // load next digit into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic q_zero;      // quotient of current step is zero
      logic cnt_last;    // this step fills the final digit slot
      logic negative;    // value held is negative
      logic k_one;       // next digit to emit is the last one
      logic out_free;    // output register can take a beat
   } status_type;

endpackage

`default_nettype wire

### design/sitda_req_if.sv
// ----------------------------------------------------------------------------
// sitda_req_if
// Input channel: one signed 32-bit value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sitda_req_if;
   import sitda_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### design/sitda_rsp_if.sv
// ----------------------------------------------------------------------------
// sitda_rsp_if
// Result channel: one ASCII character per beat, last flags end of text.
// ----------------------------------------------------------------------------
`default_nettype none

interface sitda_rsp_if;
   import sitda_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  character;
   logic               last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### design/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: accept, divide loop (multiply then digit step), sign, digits.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  sitda_pkg::status_type      stat,
   output sitda_pkg::cmd_type         cmd
);
   import sitda_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (stat.q_zero || stat.cnt_last) begin
               state_in = stat.negative ? ST_SIGN : ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (stat.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_digit = 1'b1;
               if (stat.k_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/sitda_dpath.sv
// ----------------------------------------------------------------------------
// sitda_dpath
// Magnitude, reciprocal multiply, digit store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sitda_dpath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  sitda_pkg::cmd_type                   cmd,
   output sitda_pkg::status_type                stat,
   input  wire logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [sitda_pkg::CHAR_W-1:0]         rsp_character,
   output logic                                 rsp_last
);
   import sitda_pkg::*;

   logic [VALUE_W-1:0] mag_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [CNT_W-1:0]   k_ff;
   logic [DIGIT_W-1:0] store_ff [DIGIT_SLOTS];
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;

   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] mag_load;
   logic [PROD_W-1:0]  prod;
   logic [VALUE_W-1:0] quot;
   logic [VALUE_W-1:0] quot_x10;
   logic [VALUE_W-1:0] rem_full;
   logic [DIGIT_W-1:0] digit;
   logic [CNT_W-1:0]   rd_idx;

   // two's complement magnitude; most negative value stays exact unsigned
   assign raw      = req_value;
   assign mag_load = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

   // divide by ten: one registered multiply, then shift and back-multiply
   assign prod     = mag_ff * RECIP;
   assign quot     = {{(VALUE_W-QUOT_W){1'b0}}, prod_ff[PROD_W-1:RECIP_SHIFT]};
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem_full = mag_ff - quot_x10;
   assign digit    = rem_full[DIGIT_W-1:0];
   assign cnt_in   = cnt_ff + 1'b1;

   // digits read back most significant first
   assign rd_idx   = k_ff - 1'b1;

   // status to the sequencer
   assign stat.q_zero   = (quot == '0);
   assign stat.cnt_last = (cnt_in == DIGIT_SLOTS);
   assign stat.negative = neg_ff;
   assign stat.k_one    = (k_ff == 4'd1);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // conversion registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         k_ff   <= '0;
         neg_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cnt_ff <= '0;
            neg_ff <= raw[VALUE_W-1];
         end
         if (cmd.div) begin
            cnt_ff <= cnt_in;
            k_ff   <= cnt_in;
         end
         if (cmd.emit_digit) begin
            k_ff <= rd_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_load;
      end else if (cmd.div) begin
         mag_ff <= quot;
      end
      if (cmd.mul) begin
         prod_ff <= prod;
      end
   end

   // digit store, least significant first
   always_ff @(posedge clock) begin
      if (cmd.div) begin
         store_ff[cnt_ff] <= digit;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         char_ff <= ASCII_MINUS;
         last_ff <= 1'b0;
      end else if (cmd.emit_digit) begin
         char_ff <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, store_ff[rd_idx]};
         last_ff <= (k_ff == 4'd1);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // checks
   `SITDA_ASSERT_NOW(a_rem_range, clock, reset, cmd.div, rem_full < 32'd10)
   `SITDA_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, cnt_ff <= DIGIT_SLOTS)
   `SITDA_ASSERT_NOW(a_emit_k, clock, reset, cmd.emit_digit, k_ff != 4'd0)
   `SITDA_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit_sign || cmd.emit_digit, rsp_valid_ff)

endmodule

`default_nettype wire

### design/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
//  Channel    Dir   Payload                      Beat
//  req_chan   in    value (32 b, signed)         one integer
//  rsp_chan   out   character (8 b), last (1 b)  one character, sign first
//
//  The value is accepted, then each of the D decimal digits takes a registered
//  multiply by the reciprocal of ten followed by the digit step.
//  Characters C (D, plus one for a minus) leave at one per cycle while
//  the result channel is ready; a new value is taken only once the last
//  character has been loaded into the single output register.
//  Reset is synchronous; the digit store is not cleared.
//  A stalled result channel holds the current character and pauses emission.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_top (
   input  wire logic   clock,
   input  wire logic   reset,
   sitda_req_if.sink   req_chan,
   sitda_rsp_if.source rsp_chan
);
   import sitda_pkg::*;

   cmd_type    cmd;
   status_type stat;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sitda_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_value     (req_chan.value),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_character (rsp_chan.character),
      .rsp_last      (rsp_chan.last)
   );

endmodule

`default_nettype wire

### dv/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Self-checking bench for the integer to decimal text block. A driver sends
// signed 32-bit values in random bursts. A monitor predicts the ASCII
// characters of each accepted value and checks every result beat in order.
// The receiver stalls on its own pattern and holds off once for a long
// stretch.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii_top;
   import sitda_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } char_beat_type;

   logic clock = 1'b0;
   logic reset;

   sitda_req_if req_if ();
   sitda_rsp_if rsp_if ();

   signed_int_to_decimal_ascii_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [VALUE_W-1:0] pending_values [$];
   char_beat_type      expected_chars [$];
   int                 mismatch_count = 0;
   bit                 long_hold_request = 1'b0;

   // clock
   always #5 clock = ~clock;

   // decimal text of one value, sign first, digits most significant first
   function automatic void predict_text(logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] magnitude;
      logic [DIGIT_W-1:0] digits [0:9];
      logic               negative;
      int                 count;
      negative  = raw[VALUE_W-1];
      magnitude = negative ? (~raw + 1'b1) : raw;
      count     = 0;
      do begin
         digits[count] = DIGIT_W'(magnitude % 10);
         count++;
         magnitude = magnitude / 10;
      end while (magnitude != 0 && count < DIGIT_SLOTS);
      if (negative)
         expected_chars.push_back('{character: ASCII_MINUS, last: 1'b0});
      for (int k = count; k > 0; k--) begin
         expected_chars.push_back('{character: ASCII_ZERO + digits[k-1],
                                    last: (k == 1)});
      end
   endfunction

   // mix of full-range values, short values, powers of ten and extremes
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] magnitude;
      int unsigned        kind;
      int unsigned        power;
      kind  = $urandom_range(0, 9);
      power = 1;
      repeat ($urandom_range(0, 9)) power = power * 10;
      case (kind)
         0, 1, 2: return $urandom;
         3:       magnitude = $urandom_range(0, 99);
         4:       magnitude = power + $urandom_range(0, 2) - 1;
         5: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h8000_0001;
               default: return '0;
            endcase
         end
         default: magnitude = $urandom_range(0, power - 1);
      endcase
      return $urandom_range(0, 1) ? -magnitude : magnitude;
   endfunction

   // wait until every queued value is accepted and every character is back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_values.size() != 0 || req_if.valid || expected_chars.size() != 0);
   endtask

   // input driver: bursts of beats separated by random gaps
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.value <= '0;
         burst_left   <= 1;
         gap_left     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left     <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_if.value <= pending_values.pop_front();
            req_if.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
               gap_left   <= ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40)
                                                         : $urandom_range(0, 3);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver: stall pattern follows bits 7:6 of a free-running cycle counter, one long hold-off
   logic [31:0] stall_cycle;
   int          hold_left;
   bit          hold_taken;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_cycle  <= '0;
         hold_left    <= 0;
         hold_taken   <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
         end else if (long_hold_request && !hold_taken) begin
            hold_left    <= 400;
            hold_taken   <= 1'b1;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_cycle[7:6])
               2'd0:    rsp_if.ready <= 1'b1;
               2'd1:    rsp_if.ready <= 1'($urandom_range(0, 1));
               2'd2:    rsp_if.ready <= (stall_cycle[1:0] == 2'd0);
               default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // monitor: predict on each input beat, check each result beat
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            predict_text(req_if.value);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected result beat: character %0d last %0b",
                      rsp_if.character, rsp_if.last);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.character !== want.character) begin
                  $error("character: expected %0d, got %0d",
                         want.character, rsp_if.character);
                  mismatch_count++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus phases
   initial begin
      logic [VALUE_W-1:0] directed [];
      directed = '{
         32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
         32'd100, -32'sd100, 32'd12345, -32'sd67890, 32'd999999999,
         32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001,
         32'h8000_0000, 32'd1234567890, -32'sd987654321
      };
      reset        = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero, digit-count boundaries
      foreach (directed[i]) pending_values.push_back(directed[i]);
      wait_drained();

      // random, with the receiver holding off while the sender keeps offering
      long_hold_request = 1'b1;
      repeat (175) pending_values.push_back(random_value());
      wait_drained();

      // random after a full drain
      repeat (175) pending_values.push_back(random_value());
      wait_drained();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/sitda_pkg.sv
design/sitda_req_if.sv
design/sitda_rsp_if.sv
design/sitda_ctrl.sv
design/sitda_dpath.sv
design/signed_int_to_decimal_ascii_top.sv
dv/tb_signed_int_to_decimal_ascii_top.sv
